[rtl/tff_pkg.sv]
// ============================================================================
// tff_pkg: shared types and constants of the textured triangle fragment core
// Holds the field widths, register indexes, item codes and the pipeline
// side-band structure that travels next to the arithmetic.
// ============================================================================
package tff_pkg;

    // Field widths.
    localparam int COORD_W = 10;
    localparam int POS_W   = 20;
    localparam int UV_W    = 32;
    localparam int TSIZE_W = 9;
    localparam int ADDR_W  = 16;
    localparam int RGB_W   = 24;
    localparam int CFG_W   = 32;
    localparam int IDX_W   = 3;

    // Internal arithmetic widths.
    localparam int DIFF_W  = COORD_W + 1;       // signed coordinate difference
    localparam int PROD_W  = 2 * DIFF_W;        // signed edge product
    localparam int AREA_W  = 21;                // magnitude of twice the area
    localparam int WGT_W   = 17;                // Q1.16 weight, 65536 included
    localparam int FRAC_W  = 24;                // fraction of Q8.24 uv
    localparam int TIDX_W  = 19;                // texel index before range test

    // Configuration register indexes.
    localparam logic [IDX_W-1:0] REG_VERT0_POS  = 3'd0;
    localparam logic [IDX_W-1:0] REG_VERT1_POS  = 3'd1;
    localparam logic [IDX_W-1:0] REG_VERT2_POS  = 3'd2;
    localparam logic [IDX_W-1:0] REG_VERT0_UV   = 3'd3;
    localparam logic [IDX_W-1:0] REG_VERT1_UV   = 3'd4;
    localparam logic [IDX_W-1:0] REG_VERT2_UV   = 3'd5;
    localparam logic [IDX_W-1:0] REG_TEX_WIDTH  = 3'd6;
    localparam logic [IDX_W-1:0] REG_TEX_HEIGHT = 3'd7;

    // Item codes.
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_SHADE = 1'b1;

    // Side-band carried along every pipeline stage.
    typedef struct packed {
        logic               vld;
        logic               op;
        logic               hit;
        logic [COORD_W-1:0] px;
        logic [COORD_W-1:0] py;
        logic [ADDR_W-1:0]  addr;
        logic [RGB_W-1:0]   rgb;
    } t_side;

endpackage

[rtl/tff_ram.sv]
// ============================================================================
// tff_ram: generic single-port RAM
// One access per cycle, write or read, with the read word registered.
// ============================================================================
module tff_ram #(
    parameter int WIDTH  = 24,
    parameter int DEPTH  = 65536,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [WIDTH-1:0]  i_wdata,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/tff_div.sv]
// ============================================================================
// tff_div: pipelined restoring divider for barycentric weights
// Computes floor(num * 65536 / den) for num <= den, one quotient bit per stage.
// ============================================================================
module tff_div
    import tff_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [AREA_W-1:0] i_num,
    input  logic [AREA_W-1:0] i_den,
    output logic [WGT_W-1:0]  o_quot
);

    logic [AREA_W-1:0] r_rem  [WGT_W-1];
    logic [WGT_W-1:0]  r_quot [WGT_W];

    genvar k;
    generate
        for (k = 0; k < WGT_W; k++) begin : g_step
            logic [AREA_W:0] n_part;
            logic [AREA_W:0] n_diff;
            logic            n_bit;

            if (k == 0) begin : g_first
                assign n_part = {1'b0, i_num};
            end else begin : g_next
                assign n_part = {r_rem[k-1], 1'b0};
            end

            assign n_diff = n_part - {1'b0, i_den};
            assign n_bit  = (n_part >= {1'b0, i_den});

            if (k < WGT_W - 1) begin : g_rem
                always_ff @(posedge i_clk) begin
                    if (i_en) begin
                        r_rem[k] <= n_bit ? n_diff[AREA_W-1:0] : n_part[AREA_W-1:0];
                    end
                end
            end

            if (k == 0) begin : g_q_first
                always_ff @(posedge i_clk) begin
                    if (i_en) begin
                        r_quot[k] <= {{(WGT_W-1){1'b0}}, n_bit};
                    end
                end
            end else begin : g_q_next
                always_ff @(posedge i_clk) begin
                    if (i_en) begin
                        r_quot[k] <= {r_quot[k-1][WGT_W-2:0], n_bit};
                    end
                end
            end
        end
    endgenerate

    assign o_quot = r_quot[WGT_W-1];

endmodule

[rtl/textured_triangle_fragment_shader_core.sv]
// ============================================================================
// textured_triangle_fragment_shader_core: barycentric texture-mapped shading
// Tests pixels against one configured triangle and samples its texture.
// ============================================================================
// The core accepts one word per clock while the output is not stalled: a
// load word writes one texel, a shade word returns one result word with the
// pixel coordinates, a written flag and the sampled colour. Each word passes
// 27 register stages, the last of which is the output register. The two
// weight dividers, one quotient bit per stage over 17 stages, set most of
// that depth. Loads travel down the same pipeline and write the texture
// store in the stage where shades read it, so every shade sees exactly the
// loads that were accepted before it. Results come out in order, and a stall
// at the output freezes the whole pipeline without losing or repeating a
// word. Triangle geometry is folded into the edge coefficient registers and
// then the area registers after a configuration write. The texture store
// needs no initialization; sampling a texel that was never loaded returns
// an unspecified colour.
// ============================================================================
module textured_triangle_fragment_shader_core
    import tff_pkg::*;
#(
    parameter int IMG_WIDTH  = 512,
    parameter int IMG_HEIGHT = 512,
    parameter int TEX_DEPTH  = 65536
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Configuration write port.
    input  logic               i_cfg_we,
    input  logic [IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_W-1:0]   i_cfg_data,
    // Input channel.
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_op,
    input  logic [ADDR_W-1:0]  i_texel_addr,
    input  logic [RGB_W-1:0]   i_texel_rgb,
    input  logic [COORD_W-1:0] i_pix_x,
    input  logic [COORD_W-1:0] i_pix_y,
    // Output channel.
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_written,
    output logic [COORD_W-1:0] o_out_x,
    output logic [COORD_W-1:0] o_out_y,
    output logic [RGB_W-1:0]   o_out_rgb
);

    localparam int TEX_AW = (TEX_DEPTH > 1) ? $clog2(TEX_DEPTH) : 1;

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic [POS_W-1:0]   r_vert_pos [3];
    logic [UV_W-1:0]    r_vert_uv  [3];
    logic [TSIZE_W-1:0] r_tex_width;
    logic [TSIZE_W-1:0] r_tex_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                r_vert_pos[k] <= '0;
                r_vert_uv[k]  <= '0;
            end
            r_tex_width  <= TSIZE_W'(256);
            r_tex_height <= TSIZE_W'(256);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_VERT0_POS:  r_vert_pos[0] <= i_cfg_data[POS_W-1:0];
                REG_VERT1_POS:  r_vert_pos[1] <= i_cfg_data[POS_W-1:0];
                REG_VERT2_POS:  r_vert_pos[2] <= i_cfg_data[POS_W-1:0];
                REG_VERT0_UV:   r_vert_uv[0]  <= i_cfg_data;
                REG_VERT1_UV:   r_vert_uv[1]  <= i_cfg_data;
                REG_VERT2_UV:   r_vert_uv[2]  <= i_cfg_data;
                REG_TEX_WIDTH:  r_tex_width   <= i_cfg_data[TSIZE_W-1:0];
                REG_TEX_HEIGHT: r_tex_height  <= i_cfg_data[TSIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // Edge coefficients of the triangle, then its signed doubled area. Both
    // are refreshed every cycle, so they follow configuration writes.
    logic signed [DIFF_W-1:0] r_a0, r_b0, r_a1, r_b1, r_c0;
    logic [AREA_W-1:0]        r_area_abs;
    logic                     r_area_neg;
    logic                     r_area_zero;

    logic signed [DIFF_W-1:0] n_x0, n_y0, n_x1, n_y1, n_x2, n_y2;
    logic signed [PROD_W:0]   n_area;
    logic signed [PROD_W:0]   n_area_mag;

    always_comb begin
        n_x0 = $signed({1'b0, r_vert_pos[0][COORD_W-1:0]});
        n_y0 = $signed({1'b0, r_vert_pos[0][POS_W-1:COORD_W]});
        n_x1 = $signed({1'b0, r_vert_pos[1][COORD_W-1:0]});
        n_y1 = $signed({1'b0, r_vert_pos[1][POS_W-1:COORD_W]});
        n_x2 = $signed({1'b0, r_vert_pos[2][COORD_W-1:0]});
        n_y2 = $signed({1'b0, r_vert_pos[2][POS_W-1:COORD_W]});
        n_area = (PROD_W+1)'(r_a0 * r_b1) + (PROD_W+1)'(r_b0 * r_c0);
        n_area_mag = n_area[PROD_W] ? -n_area : n_area;
    end

    always_ff @(posedge i_clk) begin
        r_a0 <= n_y1 - n_y2;
        r_b0 <= n_x2 - n_x1;
        r_a1 <= n_y2 - n_y0;
        r_b1 <= n_x0 - n_x2;
        r_c0 <= n_y0 - n_y2;
        r_area_abs  <= n_area_mag[AREA_W-1:0];
        r_area_neg  <= n_area[PROD_W];
        r_area_zero <= (n_area == '0);
    end

    // A texture size of zero behaves as one texel.
    logic [TSIZE_W-1:0] n_w_m1, n_h_m1, n_tw;
    assign n_w_m1 = (r_tex_width == '0)  ? '0 : r_tex_width - 1'b1;
    assign n_h_m1 = (r_tex_height == '0) ? '0 : r_tex_height - 1'b1;
    assign n_tw   = (r_tex_width == '0)  ? TSIZE_W'(1) : r_tex_width;

    // ------------------------------------------------------------------
    // Pipeline control. The whole pipeline moves when the output register
    // is empty or its word is taken this cycle; bubbles move along with it.
    // ------------------------------------------------------------------
    logic r_out_valid;
    logic n_adv;
    assign n_adv   = !r_out_valid || i_ready;
    assign o_ready = n_adv;

    // Stage 1: capture the word and the offsets from the third vertex.
    t_side                    r_s1;
    logic signed [DIFF_W-1:0] r_dx, r_dy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.vld <= 1'b0;
        end else if (n_adv) begin
            r_s1.vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_adv) begin
            r_s1.op   <= i_op;
            r_s1.hit  <= 1'b0;
            r_s1.px   <= i_pix_x;
            r_s1.py   <= i_pix_y;
            r_s1.addr <= i_texel_addr;
            r_s1.rgb  <= i_texel_rgb;
            r_dx <= $signed({1'b0, i_pix_x}) - n_x2;
            r_dy <= $signed({1'b0, i_pix_y}) - n_y2;
        end
    end

    // Stage 2: the edge products a0*dx, b0*dy, a1*dx and b1*dy.
    t_side                    r_s2;
    logic signed [PROD_W-1:0] r_p0, r_p1, r_p2, r_p3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2.vld <= 1'b0;
        end else if (n_adv) begin
            r_s2.vld <= r_s1.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_adv) begin
            r_s2.op   <= r_s1.op;
            r_s2.hit  <= r_s1.hit;
            r_s2.px   <= r_s1.px;
            r_s2.py   <= r_s1.py;
            r_s2.addr <= r_s1.addr;
            r_s2.rgb  <= r_s1.rgb;
            r_p0 <= r_a0 * r_dx;
            r_p1 <= r_b0 * r_dy;
            r_p2 <= r_a1 * r_dx;
            r_p3 <= r_b1 * r_dy;
        end
    end

    // Stage 3: edge values oriented by the sign of the area, the third one
    // from the other two, and the hit test against triangle and image.
    t_side             r_s3;
    logic [AREA_W-1:0] r_n0, r_n1;

    logic signed [PROD_W:0]   n_e0, n_e1;
    logic signed [PROD_W+1:0] n_n0, n_n1;
    logic signed [PROD_W+2:0] n_n2;
    logic                     n_in_img;
    logic                     n_hit;

    always_comb begin
        n_e0 = (PROD_W+1)'(r_p0) + (PROD_W+1)'(r_p1);
        n_e1 = (PROD_W+1)'(r_p2) + (PROD_W+1)'(r_p3);
        n_n0 = r_area_neg ? -(PROD_W+2)'(n_e0) : (PROD_W+2)'(n_e0);
        n_n1 = r_area_neg ? -(PROD_W+2)'(n_e1) : (PROD_W+2)'(n_e1);
        n_n2 = $signed({4'b0000, r_area_abs}) - (PROD_W+3)'(n_n0) - (PROD_W+3)'(n_n1);
        n_in_img = ({1'b0, r_s2.px} < (COORD_W+1)'(IMG_WIDTH))
                && ({1'b0, r_s2.py} < (COORD_W+1)'(IMG_HEIGHT));
        n_hit = !r_area_zero && !n_n0[PROD_W+1] && !n_n1[PROD_W+1]
             && !n_n2[PROD_W+2] && n_in_img;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3.vld <= 1'b0;
        end else if (n_adv) begin
            r_s3.vld <= r_s2.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_adv) begin
            r_s3.op   <= r_s2.op;
            r_s3.hit  <= n_hit;
            r_s3.px   <= r_s2.px;
            r_s3.py   <= r_s2.py;
            r_s3.addr <= r_s2.addr;
            r_s3.rgb  <= r_s2.rgb;
            r_n0 <= n_n0[AREA_W-1:0];
            r_n1 <= n_n1[AREA_W-1:0];
        end
    end

    // Divider stages: the side-band waits in a line as deep as the dividers.
    t_side            r_sq [WGT_W];
    logic [WGT_W-1:0] n_q0, n_q1;

    tff_div u_div0 (
        .i_clk  (i_clk),
        .i_en   (n_adv),
        .i_num  (r_n0),
        .i_den  (r_area_abs),
        .o_quot (n_q0)
    );

    tff_div u_div1 (
        .i_clk  (i_clk),
        .i_en   (n_adv),
        .i_num  (r_n1),
        .i_den  (r_area_abs),
        .o_quot (n_q1)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < WGT_W; k++) begin
                r_sq[k].vld <= 1'b0;
            end
        end else if (n_adv) begin
            r_sq[0].vld <= r_s3.vld;
            for (int k = 1; k < WGT_W; k++) begin
                r_sq[k].vld <= r_sq[k-1].vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_adv) begin
            r_sq[0].op   <= r_s3.op;
            r_sq[0].hit  <= r_s3.hit;
            r_sq[0].px   <= r_s3.px;
            r_sq[0].py   <= r_s3.py;
            r_sq[0].addr <= r_s3.addr;
            r_sq[0].rgb  <= r_s3.rgb;
            for (int k = 1; k < WGT_W; k++) begin
                r_sq[k].op   <= r_sq[k-1].op;
                r_sq[k].hit  <= r_sq[k-1].hit;
                r_sq[k].px   <= r_sq[k-1].px;
                r_sq[k].py   <= r_sq[k-1].py;
                r_sq[k].addr <= r_sq[k-1].addr;
                r_sq[k].rgb  <= r_sq[k-1].rgb;
            end
        end
    end

    // Stage A: the three weights; the third one closes the sum to one.
    t_side            r_sa;
    logic [WGT_W-1:0] r_w [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sa.vld <= 1'b0;
        end else if (n_adv) begin
            r_sa.vld <= r_sq[WGT_W-1].vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_adv) begin
            r_sa.op   <= r_sq[WGT_W-1].op;
            r_sa.hit  <= r_sq[WGT_W-1].hit;
            r_sa.px   <= r_sq[WGT_W-1].px;
            r_sa.py   <= r_sq[WGT_W-1].py;
            r_sa.addr <= r_sq[WGT_W-1].addr;
            r_sa.rgb  <= r_sq[WGT_W-1].rgb;
            r_w[0] <= n_q0;
            r_w[1] <= n_q1;
            r_w[2] <= WGT_W'(65536) - n_q0 - n_q1;
        end
    end

    // Stage B: weight times texture coordinate, kept modulo the fraction.
    t_side             r_sb;
    logic [FRAC_W-1:0] r_pu [3];
    logic [FRAC_W-1:0] r_pv [3];
    logic [WGT_W+15:0] n_mu [3];
    logic [WGT_W+15:0] n_mv [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_mu[k] = (WGT_W+16)'(r_w[k]) * (WGT_W+16)'(r_vert_uv[k][15:0]);
            n_mv[k] = (WGT_W+16)'(r_w[k]) * (WGT_W+16)'(r_vert_uv[k][31:16]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sb.vld <= 1'b0;
        end else if (n_adv) begin
            r_sb.vld <= r_sa.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_adv) begin
            r_sb.op   <= r_sa.op;
            r_sb.hit  <= r_sa.hit;
            r_sb.px   <= r_sa.px;
            r_sb.py   <= r_sa.py;
            r_sb.addr <= r_sa.addr;
            r_sb.rgb  <= r_sa.rgb;
            for (int k = 0; k < 3; k++) begin
                r_pu[k] <= n_mu[k][FRAC_W-1:0];
                r_pv[k] <= n_mv[k][FRAC_W-1:0];
            end
        end
    end

    // Stage C: fractional parts of the interpolated u and v.
    t_side             r_sc;
    logic [FRAC_W-1:0] r_fu, r_fv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sc.vld <= 1'b0;
        end else if (n_adv) begin
            r_sc.vld <= r_sb.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_adv) begin
            r_sc.op   <= r_sb.op;
            r_sc.hit  <= r_sb.hit;
            r_sc.px   <= r_sb.px;
            r_sc.py   <= r_sb.py;
            r_sc.addr <= r_sb.addr;
            r_sc.rgb  <= r_sb.rgb;
            r_fu <= r_pu[0] + r_pu[1] + r_pu[2];
            r_fv <= r_pv[0] + r_pv[1] + r_pv[2];
        end
    end

    // Stage D: scale the fractions to a column and a row, truncating.
    t_side                     r_sd;
    logic [TSIZE_W-1:0]        r_col, r_row;
    logic [FRAC_W+TSIZE_W-1:0] n_cu, n_cv;

    assign n_cu = (FRAC_W+TSIZE_W)'(r_fu) * (FRAC_W+TSIZE_W)'(n_w_m1);
    assign n_cv = (FRAC_W+TSIZE_W)'(r_fv) * (FRAC_W+TSIZE_W)'(n_h_m1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sd.vld <= 1'b0;
        end else if (n_adv) begin
            r_sd.vld <= r_sc.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_adv) begin
            r_sd.op   <= r_sc.op;
            r_sd.hit  <= r_sc.hit;
            r_sd.px   <= r_sc.px;
            r_sd.py   <= r_sc.py;
            r_sd.addr <= r_sc.addr;
            r_sd.rgb  <= r_sc.rgb;
            r_col <= n_cu[FRAC_W+TSIZE_W-1:FRAC_W];
            r_row <= n_cv[FRAC_W+TSIZE_W-1:FRAC_W];
        end
    end

    // Stage E: linear texel index.
    t_side             r_se;
    logic [TIDX_W-1:0] r_tidx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_se.vld <= 1'b0;
        end else if (n_adv) begin
            r_se.vld <= r_sd.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_adv) begin
            r_se.op   <= r_sd.op;
            r_se.hit  <= r_sd.hit;
            r_se.px   <= r_sd.px;
            r_se.py   <= r_sd.py;
            r_se.addr <= r_sd.addr;
            r_se.rgb  <= r_sd.rgb;
            r_tidx <= TIDX_W'(r_row) * TIDX_W'(n_tw) + TIDX_W'(r_col);
        end
    end

    // Stage F: texture store access. Loads write here and shades read here,
    // which keeps the store in the order in which words were accepted.
    t_side             r_sf;
    logic              r_fetch_ok;
    logic              n_fetch_ok;
    logic              n_load_ok;
    logic              n_ram_en;
    logic              n_ram_we;
    logic [TEX_AW-1:0] n_ram_addr;
    logic [RGB_W-1:0]  n_ram_rdata;

    assign n_fetch_ok = (r_tidx < TIDX_W'(TEX_DEPTH));
    assign n_load_ok  = ({1'b0, r_se.addr} < (ADDR_W+1)'(TEX_DEPTH));
    assign n_ram_en   = n_adv && r_se.vld;
    assign n_ram_we   = (r_se.op == OP_LOAD) && n_load_ok;
    assign n_ram_addr = (r_se.op == OP_LOAD) ? r_se.addr[TEX_AW-1:0]
                                             : r_tidx[TEX_AW-1:0];

    tff_ram #(
        .WIDTH (RGB_W),
        .DEPTH (TEX_DEPTH)
    ) u_tex_ram (
        .i_clk   (i_clk),
        .i_en    (n_ram_en),
        .i_we    (n_ram_we),
        .i_addr  (n_ram_addr),
        .i_wdata (r_se.rgb),
        .o_rdata (n_ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sf.vld <= 1'b0;
        end else if (n_adv) begin
            r_sf.vld <= r_se.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_adv) begin
            r_sf.op    <= r_se.op;
            r_sf.hit   <= r_se.hit;
            r_sf.px    <= r_se.px;
            r_sf.py    <= r_se.py;
            r_sf.addr  <= r_se.addr;
            r_sf.rgb   <= r_se.rgb;
            r_fetch_ok <= n_fetch_ok;
        end
    end

    // Output register: only shade words produce a result word.
    logic               r_written;
    logic [COORD_W-1:0] r_out_x, r_out_y;
    logic [RGB_W-1:0]   r_out_rgb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (n_adv) begin
            r_out_valid <= r_sf.vld && (r_sf.op == OP_SHADE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_adv) begin
            r_written <= r_sf.hit;
            r_out_x   <= r_sf.px;
            r_out_y   <= r_sf.py;
            r_out_rgb <= (r_sf.hit && r_fetch_ok) ? n_ram_rdata : '0;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_written = r_written;
    assign o_out_x   = r_out_x;
    assign o_out_y   = r_out_y;
    assign o_out_rgb = r_out_rgb;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_unwritten_black : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_written) |-> (o_out_rgb == '0))
        else $error("pixel not written but colour is nonzero");

    a_load_no_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (n_adv && r_sf.vld && (r_sf.op == OP_LOAD)) |=> !o_valid)
        else $error("load word produced a result word");

    a_hit_area : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s3.vld && r_s3.hit) |-> (r_n0 <= r_area_abs && r_n1 <= r_area_abs))
        else $error("edge value above area for a covered pixel");

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps
// ============================================================================
// Testbench for the textured triangle fragment shader core
// Loads small textures, sets up triangles through the configuration port and
// shades pixels around each triangle. Every result word is checked against a
// fixed-point barycentric predictor while both channels idle and stall.
// ============================================================================
module testbench;
    import tff_pkg::*;

    localparam int IMG_W       = 512;
    localparam int IMG_H       = 512;
    localparam int DRAIN_WAIT  = 40;      // pipeline is 27 deep
    localparam int CYCLE_LIMIT = 400000;
    localparam int NUM_PHASES  = 8;
    localparam int SHADES_PER  = 70;

    // One expected or observed result word.
    typedef struct {
        logic               written;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [RGB_W-1:0]   rgb;
    } t_pixel;

    // One row of the directed stimulus table; all rows run at reset settings.
    typedef struct {
        logic               op;
        logic [ADDR_W-1:0]  addr;
        logic [RGB_W-1:0]   rgb;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               exp_written;
        logic [RGB_W-1:0]   exp_rgb;
    } t_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [IDX_W-1:0]   i_cfg_idx = '0;
    logic [CFG_W-1:0]   i_cfg_data = '0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic               i_op = OP_LOAD;
    logic [ADDR_W-1:0]  i_texel_addr = '0;
    logic [RGB_W-1:0]   i_texel_rgb = '0;
    logic [COORD_W-1:0] i_pix_x = '0;
    logic [COORD_W-1:0] i_pix_y = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic               o_written;
    logic [COORD_W-1:0] o_out_x;
    logic [COORD_W-1:0] o_out_y;
    logic [RGB_W-1:0]   o_out_rgb;

    textured_triangle_fragment_shader_core #(
        .IMG_WIDTH(IMG_W), .IMG_HEIGHT(IMG_H), .TEX_DEPTH(65536)
    ) dut (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Shadow copy of the configuration and of the texture store.
    logic [POS_W-1:0]   tri_pos [3];
    logic [UV_W-1:0]    tri_uv [3];
    logic [TSIZE_W-1:0] tex_w = 9'd256;
    logic [TSIZE_W-1:0] tex_h = 9'd256;
    logic [RGB_W-1:0]   texels [int];

    t_pixel pending_pixels [$];
    int     errors = 0;
    int     cycles = 0;
    int     burst_left = 0;

    // Scale the fraction of one interpolated coordinate to a texel index.
    function automatic longint unsigned texel_axis(input longint unsigned w[3],
                                                   input int shift,
                                                   input logic [TSIZE_W-1:0] n);
        longint unsigned acc;
        longint unsigned size;
        acc = 0;
        for (int k = 0; k < 3; k++)
            acc += w[k] * longint'((tri_uv[k] >> shift) & 32'hFFFF);
        acc &= 64'hFF_FFFF;
        size = (n == 0) ? 1 : longint'(n);
        return (acc * (size - 1)) >> 24;
    endfunction

    // Barycentric inside test and texture sample for one pixel.
    function automatic t_pixel shade_pixel(input logic [COORD_W-1:0] px,
                                           input logic [COORD_W-1:0] py);
        t_pixel          r;
        longint          vx [3];
        longint          vy [3];
        longint          area, n0, n1, n2;
        longint unsigned w [3];
        longint unsigned col, row, idx, tw;
        for (int k = 0; k < 3; k++) begin
            vx[k] = longint'(tri_pos[k][9:0]);
            vy[k] = longint'(tri_pos[k][19:10]);
        end
        area = (vy[1] - vy[2]) * (vx[0] - vx[2]) + (vx[2] - vx[1]) * (vy[0] - vy[2]);
        n0 = (vy[1] - vy[2]) * (longint'(px) - vx[2])
           + (vx[2] - vx[1]) * (longint'(py) - vy[2]);
        n1 = (vy[2] - vy[0]) * (longint'(px) - vx[2])
           + (vx[0] - vx[2]) * (longint'(py) - vy[2]);
        if (area < 0) begin
            area = -area;
            n0 = -n0;
            n1 = -n1;
        end
        n2 = area - n0 - n1;
        r.x = px;
        r.y = py;
        r.written = 1'b0;
        r.rgb = '0;
        if (area != 0 && n0 >= 0 && n1 >= 0 && n2 >= 0 && px < IMG_W && py < IMG_H) begin
            w[0] = (n0 * 65536) / area;
            w[1] = (n1 * 65536) / area;
            w[2] = 65536 - w[0] - w[1];
            col = texel_axis(w, 0, tex_w);
            row = texel_axis(w, 16, tex_h);
            tw = (tex_w == 0) ? 1 : longint'(tex_w);
            idx = row * tw + col;
            r.written = 1'b1;
            if (idx < 65536 && texels.exists(int'(idx)))
                r.rgb = texels[int'(idx)];
        end
        return r;
    endfunction

    // Present one word and hold it until accepted. Called right after a rising
    // edge; returns right after the accepting edge, or after the gap that follows.
    task automatic send_word(input logic op, input logic [ADDR_W-1:0] addr,
                             input logic [RGB_W-1:0] rgb, input logic [COORD_W-1:0] x,
                             input logic [COORD_W-1:0] y, input bit typed,
                             input t_pixel typed_pixel);
        i_valid      <= 1'b1;
        i_op         <= op;
        i_texel_addr <= addr;
        i_texel_rgb  <= rgb;
        i_pix_x      <= x;
        i_pix_y      <= y;
        do @(posedge i_clk); while (!o_ready);
        // The word is accepted at this edge, so the shadow state moves now.
        if (op == OP_LOAD)
            texels[int'(addr)] = rgb;
        else if (typed)
            pending_pixels.push_back(typed_pixel);
        else
            pending_pixels.push_back(shade_pixel(x, y));
        if (burst_left == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(0, 12);
        end else begin
            burst_left--;
        end
    endtask

    task automatic load_texel(input logic [ADDR_W-1:0] addr, input logic [RGB_W-1:0] rgb);
        t_pixel none;
        none = '{default: '0};
        send_word(OP_LOAD, addr, rgb, COORD_W'($urandom_range(0, 1023)),
                  COORD_W'($urandom_range(0, 1023)), 1'b0, none);
    endtask

    task automatic shade(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
        t_pixel none;
        none = '{default: '0};
        send_word(OP_SHADE, ADDR_W'($urandom_range(0, 65535)),
                  RGB_W'($urandom_range(0, 24'hFFFFFF)), x, y, 1'b0, none);
    endtask

    // Let every expected word arrive, then wait out loads still in flight.
    task automatic drain;
        i_valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    // Write all eight registers on consecutive edges while the core is idle.
    task automatic write_config;
        logic [CFG_W-1:0] vals [8];
        vals[REG_VERT0_POS]  = CFG_W'(tri_pos[0]);
        vals[REG_VERT1_POS]  = CFG_W'(tri_pos[1]);
        vals[REG_VERT2_POS]  = CFG_W'(tri_pos[2]);
        vals[REG_VERT0_UV]   = tri_uv[0];
        vals[REG_VERT1_UV]   = tri_uv[1];
        vals[REG_VERT2_UV]   = tri_uv[2];
        vals[REG_TEX_WIDTH]  = CFG_W'(tex_w);
        vals[REG_TEX_HEIGHT] = CFG_W'(tex_h);
        for (int i = 0; i < 8; i++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= IDX_W'(i);
            i_cfg_data <= vals[i];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        repeat (4) @(posedge i_clk);
    endtask

    // Directed words at reset settings: every vertex at the origin means a
    // zero-area triangle, so no shade is written whatever the pixel.
    t_row reset_rows [] = '{
        '{OP_LOAD,  16'h0000, 24'h000000, 10'd0,    10'd0,    1'b0, 24'h0},
        '{OP_LOAD,  16'hFFFF, 24'hFFFFFF, 10'd1023, 10'd1023, 1'b0, 24'h0},
        '{OP_LOAD,  16'h5555, 24'h555555, 10'd0,    10'd0,    1'b0, 24'h0},
        '{OP_LOAD,  16'hAAAA, 24'hAAAAAA, 10'd0,    10'd0,    1'b0, 24'h0},
        '{OP_SHADE, 16'h0000, 24'h000000, 10'd0,    10'd0,    1'b0, 24'h0},
        '{OP_SHADE, 16'h0000, 24'h000000, 10'd1023, 10'd1023, 1'b0, 24'h0},
        '{OP_SHADE, 16'h0000, 24'h000000, 10'd511,  10'd511,  1'b0, 24'h0},
        '{OP_SHADE, 16'h0000, 24'h000000, 10'd512,  10'd0,    1'b0, 24'h0},
        '{OP_SHADE, 16'h0000, 24'h000000, 10'd0,    10'd512,  1'b0, 24'h0},
        '{OP_SHADE, 16'hFFFF, 24'hFFFFFF, 10'd341,  10'd682,  1'b0, 24'h0},
        '{OP_SHADE, 16'h1234, 24'h123456, 10'd682,  10'd341,  1'b0, 24'h0}
    };

    // Stimulus.
    initial begin
        int   minx, maxx, miny, maxy, cx, cy, span;
        logic [COORD_W-1:0] vx, vy;
        t_pixel typed_pixel;
        for (int k = 0; k < 3; k++) begin
            tri_pos[k] = '0;
            tri_uv[k] = '0;
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        foreach (reset_rows[r]) begin
            typed_pixel = '{reset_rows[r].exp_written, reset_rows[r].x,
                            reset_rows[r].y, reset_rows[r].exp_rgb};
            send_word(reset_rows[r].op, reset_rows[r].addr, reset_rows[r].rgb,
                      reset_rows[r].x, reset_rows[r].y, 1'b1, typed_pixel);
        end
        drain();

        for (int p = 0; p < NUM_PHASES; p++) begin
            // Texture size: the two extreme strips first, then small ones.
            case (p)
                0: begin
                    tex_w = 9'd256;
                    tex_h = 9'd1;
                end
                1: begin
                    tex_w = 9'd1;
                    tex_h = 9'd256;
                end
                default: begin
                    tex_w = TSIZE_W'($urandom_range(1, 16));
                    tex_h = TSIZE_W'($urandom_range(1, 16));
                end
            endcase
            // Triangle: phase 2 spans the whole coordinate range, so much of it
            // lies outside the image; phase 3 is degenerate; others are small.
            cx = $urandom_range(0, 511);
            cy = $urandom_range(0, 511);
            span = $urandom_range(2, 48);
            for (int k = 0; k < 3; k++) begin
                if (p == 2) begin
                    vx = COORD_W'($urandom_range(0, 1023));
                    vy = COORD_W'($urandom_range(0, 1023));
                end else begin
                    vx = COORD_W'(cx + $urandom_range(0, span));
                    vy = COORD_W'(cy + $urandom_range(0, span));
                end
                tri_pos[k] = {vy, vx};
                tri_uv[k] = $urandom();
            end
            if (p == 3)
                tri_pos[2] = tri_pos[0];
            write_config();

            // Fill every texel the sampler can reach.
            for (int a = 0; a < tex_w * tex_h; a++)
                load_texel(ADDR_W'(a), RGB_W'($urandom_range(0, 24'hFFFFFF)));

            minx = 1023;
            maxx = 0;
            miny = 1023;
            maxy = 0;
            for (int k = 0; k < 3; k++) begin
                if (int'(tri_pos[k][9:0]) < minx) minx = int'(tri_pos[k][9:0]);
                if (int'(tri_pos[k][9:0]) > maxx) maxx = int'(tri_pos[k][9:0]);
                if (int'(tri_pos[k][19:10]) < miny) miny = int'(tri_pos[k][19:10]);
                if (int'(tri_pos[k][19:10]) > maxy) maxy = int'(tri_pos[k][19:10]);
            end
            for (int s = 0; s < SHADES_PER; s++) begin
                // Stray loads anywhere in the store, mixed in with the shades.
                if ($urandom_range(0, 99) < 8)
                    load_texel(ADDR_W'($urandom_range(0, 65535)),
                               RGB_W'($urandom_range(0, 24'hFFFFFF)));
                if ($urandom_range(0, 99) < 85)
                    shade(COORD_W'($urandom_range(minx, maxx)),
                          COORD_W'($urandom_range(miny, maxy)));
                else
                    shade(COORD_W'($urandom_range(0, 1023)),
                          COORD_W'($urandom_range(0, 1023)));
            end
            drain();
        end

        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Result checker and receiver stall pattern. The pattern rotates through
    // always ready, random stalls and one word in four.
    always @(posedge i_clk) begin
        t_pixel want;
        cycles <= cycles + 1;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_pixels.size() == 0) begin
                $error("result word with no expected word: x=%0d y=%0d", o_out_x, o_out_y);
                errors++;
            end else begin
                want = pending_pixels.pop_front();
                if (o_written !== want.written) begin
                    $error("written: expected %0d, actual %0d", want.written, o_written);
                    errors++;
                end
                if (o_out_x !== want.x) begin
                    $error("out_x: expected %0d, actual %0d", want.x, o_out_x);
                    errors++;
                end
                if (o_out_y !== want.y) begin
                    $error("out_y: expected %0d, actual %0d", want.y, o_out_y);
                    errors++;
                end
                if (o_out_rgb !== want.rgb) begin
                    $error("out_rgb: expected %06h, actual %06h", want.rgb, o_out_rgb);
                    errors++;
                end
            end
        end
        case ((cycles >> 8) % 3)
            0: i_ready <= 1'b1;
            1: i_ready <= ($urandom_range(0, 99) < 60);
            default: i_ready <= (cycles % 4 == 0);
        endcase
    end

    // Watchdog.
    always @(posedge i_clk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

endmodule
